// ===== rtl/core/htd_pkg.sv =====
// ----------------------------------------------------------------------------
// htd_pkg
// Types, code tables and the table lookup for the tree table decoder.
// ----------------------------------------------------------------------------
package htd_pkg;

  localparam int unsigned ROM_A_LEN = 102;
  localparam int unsigned ROM_B_LEN = 100;

  localparam logic [7:0] NODE_FLAG   = 8'h80;
  localparam logic [7:0] OFFSET_MASK = 8'h7F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
    logic [7:0] char_count;
  } in_item_t;

  typedef struct packed {
    logic [6:0] symbol;
    logic       last_of_item;
    logic       message_done;
  } out_item_t;

  // Code bits in walk order, first bit in the msb.
  typedef struct packed {
    logic [7:0] code_bits;
    logic       start;
    logic [7:0] count;
  } bits_item_t;

  typedef struct packed {
    logic       valid;
    logic       final_bit;
    logic [6:0] symbol;
    logic       done;
  } pend_t;

  localparam logic [7:0] ROM_A [0:ROM_A_LEN-1] = '{
    8'ha1, 8'h81, 8'h8b, 8'h81, 8'h5e, 8'h81, 8'h81, 8'h45,
    8'h81, 8'h52, 8'h81, 8'h44, 8'h81, 8'h56, 8'h4b, 8'h81,
    8'h81, 8'h30, 8'h81, 8'h2d, 8'h81, 8'h4a, 8'h36, 8'h38,
    8'h81, 8'h20, 8'h83, 8'h81, 8'h81, 8'h48, 8'h59, 8'h43,
    8'h82, 8'h81, 8'h4d, 8'h57, 8'h81, 8'h2e, 8'h81, 8'h42,
    8'h84, 8'h81, 8'h31, 8'h81, 8'h5a, 8'h81, 8'h34, 8'h33,
    8'h86, 8'h81, 8'h51, 8'h81, 8'h81, 8'h32, 8'h81, 8'h25,
    8'h2b, 8'h81, 8'h23, 8'h28, 8'h81, 8'h3f, 8'h39, 8'h81,
    8'h37, 8'h2a, 8'h86, 8'h81, 8'h84, 8'h81, 8'h54, 8'h81,
    8'h81, 8'h4c, 8'h50, 8'h46, 8'h53, 8'h4f, 8'h82, 8'h81,
    8'h4e, 8'h41, 8'h49, 8'h81, 8'h81, 8'h55, 8'h81, 8'h47,
    8'h2c, 8'h81, 8'h81, 8'h58, 8'h27, 8'h81, 8'h81, 8'h21,
    8'h35, 8'h81, 8'h26, 8'h81, 8'h29, 8'h2f
  };

  localparam logic [7:0] ROM_B [0:ROM_B_LEN-1] = '{
    8'h9c, 8'h81, 8'h96, 8'h81, 8'h81, 8'h20, 8'h83, 8'h81,
    8'h81, 8'h48, 8'h59, 8'h43, 8'h82, 8'h81, 8'h4d, 8'h57,
    8'h81, 8'h2e, 8'h81, 8'h42, 8'h84, 8'h81, 8'h31, 8'h81,
    8'h5a, 8'h81, 8'h34, 8'h33, 8'h86, 8'h81, 8'h51, 8'h81,
    8'h81, 8'h32, 8'h81, 8'h25, 8'h2b, 8'h81, 8'h23, 8'h28,
    8'h81, 8'h3f, 8'h39, 8'h81, 8'h37, 8'h2a, 8'h84, 8'h81,
    8'h54, 8'h81, 8'h81, 8'h4c, 8'h50, 8'h46, 8'h53, 8'h4f,
    8'h8d, 8'h81, 8'h82, 8'h81, 8'h4e, 8'h41, 8'h49, 8'h81,
    8'h81, 8'h55, 8'h81, 8'h47, 8'h2c, 8'h81, 8'h81, 8'h58,
    8'h27, 8'h81, 8'h81, 8'h21, 8'h35, 8'h81, 8'h26, 8'h81,
    8'h29, 8'h2f, 8'h81, 8'h45, 8'h81, 8'h52, 8'h81, 8'h44,
    8'h81, 8'h56, 8'h4b, 8'h81, 8'h81, 8'h30, 8'h81, 8'h2d,
    8'h81, 8'h4a, 8'h36, 8'h38
  };

  // Entries past the selected table or past the limit read as a zero leaf.
  function automatic logic [7:0] rom_read(input logic sel, input logic [7:0] idx,
                                          input int unsigned limit);
    logic [7:0] e;
    e = 8'h00;
    if (32'(idx) < limit) begin
      if (sel) begin
        if (32'(idx) < ROM_B_LEN) e = ROM_B[idx[6:0]];
      end else begin
        if (32'(idx) < ROM_A_LEN) e = ROM_A[idx[6:0]];
      end
    end
    return e;
  endfunction

endpackage

// ===== rtl/core/huffman_tree_table_decoder.sv =====
// A walked symbol waits in the pending register and then goes into the
// output queue: as soon as the queue has room when it ends its byte, else
// after the next symbol or the byte's last code bit is walked.
// Throughput: one code bit per cycle through the ROM lookup loop while no
// result stall holds it; a start byte gives one code bit, a skipped byte none.
// Reset: synchronous, active low; clears queues, walk state and table_select.
// ----------------------------------------------------------------------------
// huffman_tree_table_decoder
// Bit-serial Huffman decoder over one of two fixed code tables, queue ports both sides.
// ----------------------------------------------------------------------------
module huffman_tree_table_decoder #(
  parameter int unsigned TABLE_ENTRIES = 102
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  htd_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output htd_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import htd_pkg::*;

  logic       table_select_r;
  bits_item_t item;
  logic       item_valid, item_pop;
  logic       res_push, res_full;
  out_item_t  res_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_select_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      table_select_r <= cfg_data;
    end
  end

  htd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .item_pop  (item_pop),
    .item      (item),
    .item_valid(item_valid)
  );

  htd_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .table_select(table_select_r),
    .item_valid  (item_valid),
    .item        (item),
    .item_pop    (item_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_item    (res_item)
  );

  htd_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(4)
  ) u_out_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_push),
    .wr_data(res_item),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(out_item),
    .empty  (empty)
  );

endmodule

// ===== rtl/core/htd_fifo.sv =====
// ----------------------------------------------------------------------------
// htd_fifo
// Small register FIFO with full/empty flags.
// ----------------------------------------------------------------------------
module htd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/htd_front.sv =====
// ----------------------------------------------------------------------------
// htd_front
// Takes input bytes, puts their code bits in walk order and queues them.
// ----------------------------------------------------------------------------
module htd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  htd_pkg::in_item_t   in_item,
  output logic                full,
  input  logic                item_pop,
  output htd_pkg::bits_item_t item,
  output logic                item_valid
);
  import htd_pkg::*;

  bits_item_t cls;
  logic       q_empty;

  // Start byte gives bit 7 only; others give bits 6..0 then bit 7.
  always_comb begin
    cls.start = in_item.message_start;
    cls.count = in_item.char_count;
    if (in_item.message_start) begin
      cls.code_bits = {in_item.data_byte[7], 7'b0};
    end else begin
      cls.code_bits = {in_item.data_byte[6:0], in_item.data_byte[7]};
    end
  end

  htd_fifo #(
    .WIDTH($bits(bits_item_t)),
    .DEPTH(2)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_data(cls),
    .full   (full),
    .rd_en  (item_pop),
    .rd_data(item),
    .empty  (q_empty)
  );

  assign item_valid = !q_empty;

endmodule

// ===== rtl/core/htd_back.sv =====
// ----------------------------------------------------------------------------
// htd_back
// Walks the code tree one bit per cycle while the result side does not stall, and emits decoded symbols.
// ----------------------------------------------------------------------------
module htd_back #(
  parameter int unsigned TABLE_ENTRIES = 102
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                table_select,
  input  logic                item_valid,
  input  htd_pkg::bits_item_t item,
  output logic                item_pop,
  input  logic                res_full,
  output logic                res_push,
  output htd_pkg::out_item_t  res_item
);
  import htd_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic [6:0] offset_r, offset_nxt;
  logic [7:0] chars_r, chars_nxt;
  pend_t      pend_r, pend_nxt;

  logic       stall, step, last_bit, code_bit, leaf;
  logic [7:0] cl, cl_dec;
  logic [6:0] off;
  logic [7:0] entry;

  assign stall    = pend_r.valid && res_full;
  assign step     = item_valid && !stall;
  assign cl       = item.start ? item.count : chars_r;
  assign cl_dec   = cl - 1'b1;
  assign off      = item.start ? 7'd0 : offset_r;
  assign last_bit = item.start || (idx_r == 3'd7);
  assign code_bit = item.code_bits[3'd7 - idx_r];
  assign entry    = rom_read(table_select, {1'b0, off} + {7'b0, code_bit}, TABLE_ENTRIES);
  assign leaf     = (entry & NODE_FLAG) == 8'h00;

  always_comb begin
    idx_nxt    = idx_r;
    offset_nxt = offset_r;
    chars_nxt  = chars_r;
    pend_nxt   = pend_r;
    item_pop   = 1'b0;
    res_push   = 1'b0;
    res_item   = '{symbol: pend_r.symbol, last_of_item: 1'b1, message_done: pend_r.done};

    if (pend_r.valid && pend_r.final_bit && !stall) begin
      res_push       = 1'b1;
      pend_nxt.valid = 1'b0;
    end

    if (step) begin
      chars_nxt  = cl;
      offset_nxt = off;
      if (cl != 8'd0) begin
        if (leaf) begin
          chars_nxt  = cl_dec;
          offset_nxt = 7'd0;
          if (pend_r.valid && !pend_r.final_bit) begin
            res_push              = 1'b1;
            res_item.last_of_item = 1'b0;
          end
          pend_nxt.valid     = 1'b1;
          pend_nxt.final_bit = last_bit || (cl_dec == 8'd0);
          pend_nxt.symbol    = entry[6:0];
          pend_nxt.done      = (cl_dec == 8'd0);
        end else begin
          offset_nxt = off + {entry[5:0], 1'b0};
          if (last_bit && pend_r.valid && !pend_r.final_bit) begin
            pend_nxt.final_bit = 1'b1;
          end
        end
      end
      if (last_bit || (cl == 8'd0) || (leaf && (cl_dec == 8'd0))) begin
        item_pop = 1'b1;
        idx_nxt  = 3'd0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      offset_r <= '0;
      chars_r  <= '0;
      pend_r   <= '0;
    end else begin
      idx_r    <= idx_nxt;
      offset_r <= offset_nxt;
      chars_r  <= chars_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule

// ===== rtl/core/htd_checker.sv =====
// ----------------------------------------------------------------------------
// htd_checker
// Port-level checks for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module htd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input htd_pkg::out_item_t out_item,
  input logic               cfg_ready
);
  import htd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("waiting result changed before transfer");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_item.message_done |-> out_item.last_of_item)
    else $error("message_done without last_of_item");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

endmodule

bind huffman_tree_table_decoder htd_checker u_htd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item),
  .cfg_ready(cfg_ready)
);

// ===== test/huffman_tree_table_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_table_decoder_tb
// Feeds compressed bytes through the queue ports under random push and pop
// gaps and checks every decoded symbol against a bit-serial tree walker in
// the bench, or for typed rows against known results. A short directed table
// covers the count limits, start bytes during a walk and both code tables.
// Random messages follow across several table settings, one long result
// hold-off and a final stretch with no gaps on either side.
// ----------------------------------------------------------------------------
module huffman_tree_table_decoder_tb;
  import htd_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 102;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_ITEMS   = 31;
  localparam int PHASES        = 4;
  localparam int DIRECTED_ROWS = 25;

  localparam logic TBL_A = 1'b0;
  localparam logic TBL_B = 1'b1;
  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;
  localparam logic START = 1'b1;
  localparam logic CONT  = 1'b0;

  localparam out_item_t NO_SYM     = '0;
  localparam out_item_t SYM_E      = {7'h45, 1'b0, 1'b0};
  localparam out_item_t SYM_E_LAST = {7'h45, 1'b1, 1'b1};

  typedef struct packed {
    logic       table_select;
    logic       typed;
    logic [1:0] n_typed;
    out_item_t  first;
    out_item_t  second;
    in_item_t   item;
  } directed_row_t;

  // Typed rows: known results only; all others go through the tree walker.
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    {TBL_A, TYPED,     2'd0, NO_SYM, NO_SYM,     8'hFF, CONT,  8'h00},
    {TBL_A, TYPED,     2'd0, NO_SYM, NO_SYM,     8'h00, CONT,  8'hFF},
    {TBL_A, TYPED,     2'd0, NO_SYM, NO_SYM,     8'h80, START, 8'h02},
    {TBL_A, TYPED,     2'd2, SYM_E,  SYM_E_LAST, 8'hFF, CONT,  8'h00},
    {TBL_A, TYPED,     2'd0, NO_SYM, NO_SYM,     8'hFF, CONT,  8'hFF},
    {TBL_A, TYPED,     2'd0, NO_SYM, NO_SYM,     8'h00, START, 8'h00},
    {TBL_A, TYPED,     2'd0, NO_SYM, NO_SYM,     8'hA5, CONT,  8'h5A},
    {TBL_A, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'h00, START, 8'hFF},
    {TBL_A, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'h00, CONT,  8'h00},
    {TBL_A, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'h7F, CONT,  8'h00},
    {TBL_A, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'h80, CONT,  8'h00},
    {TBL_A, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'h55, CONT,  8'h00},
    {TBL_A, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'hAA, CONT,  8'h00},
    {TBL_A, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'h80, START, 8'h03},
    {TBL_A, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'h3C, CONT,  8'h00},
    {TBL_A, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'hC3, CONT,  8'h00},
    {TBL_B, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'h80, START, 8'hFF},
    {TBL_B, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'hFF, CONT,  8'h00},
    {TBL_B, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'h00, CONT,  8'h00},
    {TBL_B, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'h5A, CONT,  8'h00},
    {TBL_B, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'h00, START, 8'hFF},
    {TBL_B, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'hA5, CONT,  8'h00},
    {TBL_B, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'h80, START, 8'h01},
    {TBL_B, PREDICTED, 2'd0, NO_SYM, NO_SYM,     8'h6E, CONT,  8'h00},
    {TBL_B, TYPED,     2'd0, NO_SYM, NO_SYM,     8'h00, START, 8'h00}
  };

  localparam logic PHASE_SEL [PHASES] = '{TBL_B, TBL_A, TBL_B, TBL_A};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  // Walker state
  logic       table_sel;
  logic [6:0] walk_offset;
  logic [7:0] chars_remaining;

  out_item_t expected_syms[$];
  out_item_t want;
  int        mismatches = 0;
  int        cycles = 0;
  int        hold_requests = 0;
  logic      calm = 1'b0;

  huffman_tree_table_decoder #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] table_entry(input logic [7:0] idx);
    if (idx >= TABLE_ENTRIES) return 8'h00;
    if (table_sel) return (idx < ROM_B_LEN) ? ROM_B[idx[6:0]] : 8'h00;
    return (idx < ROM_A_LEN) ? ROM_A[idx[6:0]] : 8'h00;
  endfunction

  // Walks the code bits of one byte; queues the symbols when enqueue is set.
  function automatic void decode_byte(input in_item_t it, input logic enqueue);
    int        bit_pos [8];
    int        nbits;
    int        first_sym;
    int        i;
    logic [7:0] e;
    out_item_t sym;
    first_sym = expected_syms.size();
    if (it.message_start) begin
      chars_remaining = it.char_count;
      walk_offset = '0;
      bit_pos[0] = 7;
      nbits = 1;
    end else begin
      for (i = 0; i < 7; i++) bit_pos[i] = 6 - i;
      bit_pos[7] = 7;
      nbits = 8;
    end
    for (i = 0; i < nbits && chars_remaining != 0; i++) begin
      e = table_entry({1'b0, walk_offset} + 8'(it.data_byte[bit_pos[i]]));
      if (!e[7]) begin
        chars_remaining = chars_remaining - 8'd1;
        walk_offset = '0;
        sym.symbol = e[6:0];
        sym.last_of_item = 1'b0;
        sym.message_done = (chars_remaining == 0);
        if (enqueue) expected_syms.push_back(sym);
      end else begin
        walk_offset = walk_offset + {e[5:0], 1'b0};
      end
    end
    if (enqueue && expected_syms.size() > first_sym)
      expected_syms[expected_syms.size() - 1].last_of_item = 1'b1;
  endfunction

  task automatic send_item(input in_item_t it);
    in_item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_syms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_table_select(input logic sel);
    cfg_data <= sel;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    table_sel = sel;
  endtask

  // Result side: random stalls, one long hold-off on request, none when calm
  initial begin : result_side
    int stall_left;
    int hold_left;
    int holds_done;
    stall_left = 0;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = LONG_HOLD - 1;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_syms.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected symbol %h last %b done %b", out_item.symbol,
                   out_item.last_of_item, out_item.message_done);
      end else begin
        want = expected_syms.pop_front();
        if (out_item.symbol !== want.symbol ||
            out_item.last_of_item !== want.last_of_item ||
            out_item.message_done !== want.message_done) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("symbol mismatch: exp %h/%b/%b got %h/%b/%b", want.symbol,
                     want.last_of_item, want.message_done, out_item.symbol,
                     out_item.last_of_item, out_item.message_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : byte_side
    directed_row_t row;
    in_item_t      it;
    int            k;
    int            ph;
    int            useful;
    int            msg_left;
    int            pick;
    table_sel = TBL_A;
    walk_offset = '0;
    chars_remaining = '0;
    msg_left = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_table_select(TBL_A);

    for (k = 0; k < DIRECTED_ROWS; k++) begin
      row = DIRECTED[k];
      if (row.table_select != table_sel) begin
        drain();
        write_table_select(row.table_select);
      end
      send_item(row.item);
      decode_byte(row.item, !row.typed);
      if (row.typed) begin
        if (row.n_typed > 0) expected_syms.push_back(row.first);
        if (row.n_typed > 1) expected_syms.push_back(row.second);
      end
      maybe_gap();
    end

    // Random messages; the second phase runs into a long result hold-off
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      write_table_select(PHASE_SEL[ph]);
      if (ph == 1) hold_requests++;
      if (ph == PHASES - 1) calm = 1'b1;
      useful = 0;
      while (useful < PHASE_ITEMS) begin
        if (msg_left == 0 || $urandom_range(0, 24) == 0) begin
          pick = $urandom_range(0, 19);
          it.message_start = START;
          if (pick == 0) begin
            it.char_count = 8'd0;
            msg_left = $urandom_range(0, 2);
          end else if (pick == 1) begin
            it.char_count = 8'hFF;
            msg_left = $urandom_range(4, 20);
          end else begin
            it.char_count = 8'($urandom_range(1, 12));
            msg_left = it.char_count * 5 / 7 + $urandom_range(1, 3);
          end
        end else begin
          it.message_start = CONT;
          it.char_count = 8'($urandom);
          msg_left--;
        end
        it.data_byte = 8'($urandom);
        useful++;
        send_item(it);
        decode_byte(it, 1'b1);
        if (ph != 1) maybe_gap();
      end
    end

    drain();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/htd_pkg.sv
rtl/core/htd_fifo.sv
rtl/core/htd_front.sv
rtl/core/htd_back.sv
rtl/core/huffman_tree_table_decoder.sv
rtl/core/htd_checker.sv
test/huffman_tree_table_decoder_tb.sv
